### sv/block_decimating_axis_filter_assert.svh
// ----------------------------------------------------------------------------
// Block decimating axis filter assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_DECIMATING_AXIS_FILTER_ASSERT_SVH
`define BLOCK_DECIMATING_AXIS_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDAF_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bdaf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDAF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bdaf: next-cycle check failed");

`endif

### sv/bdaf_pkg.sv
// ----------------------------------------------------------------------------
// Block decimating axis filter package
// Shared widths, register codes, stage control types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdaf_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_TAPS   = 4;

   localparam int PIXEL_W     = 16;
   localparam int COEF_W      = 16;
   localparam int PROD_W      = PIXEL_W + COEF_W;
   localparam int VALUE_W     = 19;
   localparam int FRAC_BITS   = 14;
   localparam int NUM_COEF    = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic signed [VALUE_W-1:0] VALUE_HI = 19'sh3FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_LO = 19'sh40000;

   localparam int RST_TAPS         = 2;
   localparam int RST_IMAGE_WIDTH  = 1024;
   localparam int RST_IMAGE_HEIGHT = 1024;
   localparam logic signed [COEF_W-1:0] RST_COEF_ZERO  = 16'sd8192;
   localparam logic signed [COEF_W-1:0] RST_COEF_ONE   = 16'sd8192;
   localparam logic signed [COEF_W-1:0] RST_COEF_TWO   = 16'sd0;
   localparam logic signed [COEF_W-1:0] RST_COEF_THREE = 16'sd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VERTICAL_MODE = 3'd0,
      CSR_TAPS          = 3'd1,
      CSR_IMAGE_WIDTH   = 3'd2,
      CSR_IMAGE_HEIGHT  = 3'd3,
      CSR_COEF_ZERO     = 3'd4,
      CSR_COEF_ONE      = 3'd5,
      CSR_COEF_TWO      = 3'd6,
      CSR_COEF_THREE    = 3'd7
   } csr_index_type;

   // Per-request control that travels down the accumulate pipeline.
   typedef struct packed {
      logic valid;
      logic vertical;
      logic first;
      logic active;
      logic emit;
      logic row_end;
      logic frame_end;
   } ctl_type;

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic                      row_end;
      logic                      frame_end;
   } res_type;

   // A size of zero acts as one, and a size above the maximum acts as the maximum.
   function automatic int clamp_size(input int v, input int hi);
      int r;
      if (v == 0) begin
         r = 1;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### sv/bdaf_accum.sv
// ----------------------------------------------------------------------------
// Block decimating axis filter accumulate pipeline
// Multiplies each pixel by its tap coefficient and accumulates into a running
// sum (horizontal) or into a per-column line memory (vertical), then rounds
// down by the fraction bits and saturates the finished sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdaf_accum #(
   parameter int MAX_WIDTH = bdaf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_TAPS  = bdaf_pkg::DEF_MAX_TAPS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  bdaf_pkg::ctl_type                        ctl_in,
   input  logic [$clog2(MAX_WIDTH)-1:0]             addr_in,
   input  logic signed [bdaf_pkg::PIXEL_W-1:0]      pixel_in,
   input  logic signed [bdaf_pkg::COEF_W-1:0]       coef_in,
   output bdaf_pkg::res_type                        res
);
   import bdaf_pkg::*;

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
   localparam int QW    = ACC_W - FRAC_BITS;
   localparam logic signed [QW-1:0] Q_HI = QW'(VALUE_HI);
   localparam logic signed [QW-1:0] Q_LO = QW'(VALUE_LO);

   logic signed [ACC_W-1:0] line_mem [MAX_WIDTH];

   ctl_type                    s1_ctl_ff;
   logic [XW-1:0]              s1_addr_ff;
   logic signed [PIXEL_W-1:0]  s1_pixel_ff;
   logic signed [COEF_W-1:0]   s1_coef_ff;
   logic signed [ACC_W-1:0]    s1_rd_ff;

   ctl_type                    s2_ctl_ff;
   logic [XW-1:0]              s2_addr_ff;
   logic signed [PROD_W-1:0]   s2_prod_ff;
   logic signed [ACC_W-1:0]    s2_rd_ff;

   logic signed [ACC_W-1:0]    run_ff;

   // The last two line writes, for requests whose read went out before them.
   logic                       wh1_valid_ff;
   logic [XW-1:0]              wh1_addr_ff;
   logic signed [ACC_W-1:0]    wh1_data_ff;
   logic                       wh2_valid_ff;
   logic [XW-1:0]              wh2_addr_ff;
   logic signed [ACC_W-1:0]    wh2_data_ff;

   logic signed [ACC_W-1:0]    old_sum;
   logic signed [ACC_W-1:0]    sum;
   logic signed [QW-1:0]       quot;
   logic signed [VALUE_W-1:0]  value_sat;
   logic                       do_acc;
   logic                       wr_en;

   always_comb begin
      if (!s2_ctl_ff.vertical) begin
         old_sum = run_ff;
      end else if (wh1_valid_ff && (wh1_addr_ff == s2_addr_ff)) begin
         old_sum = wh1_data_ff;
      end else if (wh2_valid_ff && (wh2_addr_ff == s2_addr_ff)) begin
         old_sum = wh2_data_ff;
      end else begin
         old_sum = s2_rd_ff;
      end
      sum = (s2_ctl_ff.first ? '0 : old_sum) + ACC_W'(s2_prod_ff);
   end

   always_comb begin
      quot = $signed(sum[ACC_W-1:FRAC_BITS]);
      if (quot > Q_HI) begin
         value_sat = VALUE_HI;
      end else if (quot < Q_LO) begin
         value_sat = VALUE_LO;
      end else begin
         value_sat = quot[VALUE_W-1:0];
      end
   end

   assign do_acc = adv && s2_ctl_ff.valid && s2_ctl_ff.active;
   assign wr_en  = do_acc && s2_ctl_ff.vertical;

   always_comb begin
      res.valid     = s2_ctl_ff.valid && s2_ctl_ff.emit;
      res.value     = value_sat;
      res.row_end   = s2_ctl_ff.row_end;
      res.frame_end = s2_ctl_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[s2_addr_ff] <= sum;
      end
      if (adv) begin
         s1_rd_ff <= line_mem[addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff    <= '0;
         s2_ctl_ff    <= '0;
         wh1_valid_ff <= 1'b0;
         wh2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_ctl_ff    <= ctl_in;
         s2_ctl_ff    <= s1_ctl_ff;
         wh1_valid_ff <= wr_en;
         wh2_valid_ff <= wh1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_addr_ff  <= addr_in;
         s1_pixel_ff <= pixel_in;
         s1_coef_ff  <= coef_in;
         s2_addr_ff  <= s1_addr_ff;
         s2_prod_ff  <= s1_pixel_ff * s1_coef_ff;
         s2_rd_ff    <= s1_rd_ff;
         wh1_addr_ff <= s2_addr_ff;
         wh1_data_ff <= sum;
         wh2_addr_ff <= wh1_addr_ff;
         wh2_data_ff <= wh1_data_ff;
      end
      if (do_acc && !s2_ctl_ff.vertical) begin
         run_ff <= sum;
      end
   end

endmodule

### sv/block_decimating_axis_filter.sv
// ----------------------------------------------------------------------------
// Block decimating axis filter
// Non-overlapping decimating dot-product filter along the rows or the columns
// of a raster image of signed pixels, with Q2.14 coefficients.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake             Carries
//   req_*     in          req_valid/req_stall   one pixel
//   rsp_*     out         rsp_valid/rsp_stall   value, row_end, frame_end
//   csr_*     in          csr_valid/csr_ready   register index and data
//
// One pixel is taken per clock while req_stall is low; each pixel passes the
// s1 and s2 stages and a finished result is then held in the output register.
// The rate is set by one multiply-accumulate and one read-modify-write of the
// column-sum memory per pixel, with the last two writes forwarded. Reset is
// synchronous; the column memory is not cleared. req_stall is high only while
// a result waits under rsp_stall and the next one has reached the last stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_decimating_axis_filter #(
   parameter int MAX_WIDTH  = bdaf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bdaf_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_TAPS   = bdaf_pkg::DEF_MAX_TAPS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [bdaf_pkg::PIXEL_W-1:0]     req_pixel,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [bdaf_pkg::VALUE_W-1:0]     rsp_value,
   output logic                                    rsp_row_end,
   output logic                                    rsp_frame_end,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [bdaf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [bdaf_pkg::CSR_DATA_W-1:0]         csr_data
);
   import bdaf_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int TW = $clog2(MAX_TAPS + 1);
   localparam int PW = $clog2(MAX_TAPS);
   localparam int AW = CW + 1;
   localparam int BW = HW + 1;
   localparam int RST_W = clamp_size(RST_IMAGE_WIDTH, MAX_WIDTH);
   localparam int RST_H = clamp_size(RST_IMAGE_HEIGHT, MAX_HEIGHT);
   localparam int RST_T = clamp_size(RST_TAPS, MAX_TAPS);

   // Configuration, held in its effective (clamped) form.
   logic                      vertical_ff, vertical_in;
   logic [TW-1:0]             taps_ff, taps_in;
   logic [CW-1:0]             width_ff, width_in;
   logic [HW-1:0]             height_ff, height_in;
   logic signed [COEF_W-1:0]  coef_ff [NUM_COEF];
   logic signed [COEF_W-1:0]  coef_in [NUM_COEF];
   logic                      restart;

   logic [XW-1:0]             x_ff, x_in;
   logic [YW-1:0]             y_ff, y_in;
   logic [PW-1:0]             ph_ff, ph_in;

   logic                      out_valid_ff, out_valid_in;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic                      out_row_end_ff;
   logic                      out_frame_end_ff;

   logic                      adv;
   logic                      accept;
   logic                      x_last;
   logic                      y_last;
   logic                      ph_last;
   logic [PW-1:0]             ph_next;
   logic [AW-1:0]             x_block_end;
   logic [BW-1:0]             y_block_end;
   logic                      h_active;
   logic                      v_active;
   logic signed [COEF_W-1:0]  coef_sel;
   ctl_type                   ctl;
   res_type                   res;

   assign csr_ready = 1'b1;

   always_comb begin
      vertical_in = vertical_ff;
      taps_in     = taps_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      coef_in     = coef_ff;
      restart     = 1'b0;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_VERTICAL_MODE: begin
               vertical_in = csr_data[0];
               restart     = 1'b1;
            end
            CSR_TAPS: begin
               taps_in = TW'(clamp_size(int'(csr_data[2:0]), MAX_TAPS));
               restart = 1'b1;
            end
            CSR_IMAGE_WIDTH: begin
               width_in = CW'(clamp_size(int'(csr_data[10:0]), MAX_WIDTH));
               restart  = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = HW'(clamp_size(int'(csr_data[10:0]), MAX_HEIGHT));
               restart   = 1'b1;
            end
            CSR_COEF_ZERO:  coef_in[0] = $signed(csr_data);
            CSR_COEF_ONE:   coef_in[1] = $signed(csr_data);
            CSR_COEF_TWO:   coef_in[2] = $signed(csr_data);
            CSR_COEF_THREE: coef_in[3] = $signed(csr_data);
            default: ;
         endcase
      end
   end

   // The pipeline only holds when the output register is full and stalled and
   // another finished result is ready to replace it.
   assign adv       = !(res.valid && out_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_comb begin
      x_last      = (AW'(x_ff) + AW'(1)) >= AW'(width_ff);
      y_last      = (BW'(y_ff) + BW'(1)) >= BW'(height_ff);
      ph_last     = (TW'(ph_ff) + TW'(1)) == taps_ff;
      ph_next     = ph_last ? '0 : PW'(TW'(ph_ff) + TW'(1));
      // The block holding this pixel (or row) ends inside the image only if its
      // start plus the tap count does not run past the size.
      h_active    = (AW'(x_ff) - AW'(ph_ff) + AW'(taps_ff)) <= AW'(width_ff);
      v_active    = (BW'(y_ff) - BW'(ph_ff) + BW'(taps_ff)) <= BW'(height_ff);
      x_block_end = AW'(x_ff) + AW'(1) + AW'(taps_ff);
      y_block_end = BW'(y_ff) + BW'(1) + BW'(taps_ff);
      if (int'(ph_ff) < NUM_COEF) begin
         coef_sel = coef_ff[2'(ph_ff)];
      end else begin
         coef_sel = '0;
      end
   end

   always_comb begin
      ctl.valid    = accept;
      ctl.vertical = vertical_ff;
      ctl.first    = (ph_ff == '0);
      if (!vertical_ff) begin
         ctl.active    = h_active;
         ctl.emit      = h_active && ph_last;
         ctl.row_end   = x_block_end > AW'(width_ff);
         ctl.frame_end = ctl.row_end && y_last;
      end else begin
         ctl.active    = v_active;
         ctl.emit      = v_active && ph_last;
         ctl.row_end   = x_last;
         ctl.frame_end = x_last && (y_block_end > BW'(height_ff));
      end
   end

   always_comb begin
      x_in  = x_ff;
      y_in  = y_ff;
      ph_in = ph_ff;
      if (restart) begin
         x_in  = '0;
         y_in  = '0;
         ph_in = '0;
      end else if (accept) begin
         if (!x_last) begin
            x_in = x_ff + XW'(1);
            if (!vertical_ff) begin
               ph_in = ph_next;
            end
         end else begin
            x_in = '0;
            if (y_last) begin
               y_in  = '0;
               ph_in = '0;
            end else begin
               y_in  = y_ff + YW'(1);
               ph_in = vertical_ff ? ph_next : '0;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (adv && res.valid) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertical_ff  <= 1'b0;
         taps_ff      <= TW'(RST_T);
         width_ff     <= CW'(RST_W);
         height_ff    <= HW'(RST_H);
         coef_ff[0]   <= RST_COEF_ZERO;
         coef_ff[1]   <= RST_COEF_ONE;
         coef_ff[2]   <= RST_COEF_TWO;
         coef_ff[3]   <= RST_COEF_THREE;
         x_ff         <= '0;
         y_ff         <= '0;
         ph_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         vertical_ff  <= vertical_in;
         taps_ff      <= taps_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         coef_ff      <= coef_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         ph_ff        <= ph_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res.valid) begin
         out_value_ff     <= res.value;
         out_row_end_ff   <= res.row_end;
         out_frame_end_ff <= res.frame_end;
      end
   end

   bdaf_accum #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_TAPS  (MAX_TAPS)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .ctl_in   (ctl),
      .addr_in  (x_ff),
      .pixel_in (req_pixel),
      .coef_in  (coef_sel),
      .res      (res)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_value     = out_value_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_frame_end = out_frame_end_ff;

endmodule

### sv/bdaf_checker.sv
// ----------------------------------------------------------------------------
// Block decimating axis filter port checker
// Watches the top-level ports for stall, flag and reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_decimating_axis_filter_assert.svh"

module bdaf_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [bdaf_pkg::VALUE_W-1:0]  rsp_value,
   input logic                                 rsp_row_end,
   input logic                                 rsp_frame_end
);

   logic rsp_held;

   assign rsp_held = rsp_valid && rsp_stall;

   // Requests are held back only while a result sits stalled at the output.
   `BDAF_ASSERT_IMPLY(a_stall_needs_full_out, clock, reset, req_stall, rsp_valid && rsp_stall)

   // The last result of a frame is also the last of its row.
   `BDAF_ASSERT_IMPLY(a_frame_end_on_row_end, clock, reset, rsp_valid && rsp_frame_end, rsp_row_end)

   `BDAF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_value))

   // Reset empties the output and opens the request side.
   `BDAF_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind block_decimating_axis_filter bdaf_checker u_bdaf_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Block decimating axis filter testbench
// Streams raster frames under many geometries and coefficient sets, predicts
// each decimated sample in the bench and compares every result field by field,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   import bdaf_pkg::*;

   localparam int unsigned RANDOM_PIXELS = 360;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned QUIET_LIMIT   = 5000;
   localparam int unsigned MAX_REPORTS   = 40;

   typedef enum logic [1:0] {
      PLAN_PIXEL,
      PLAN_REGISTER,
      PLAN_DRAIN
   } plan_kind_type;

   typedef struct {
      plan_kind_type               kind;
      logic signed [PIXEL_W-1:0]   pixel;
      csr_index_type               index;
      logic [CSR_DATA_W-1:0]       data;
      int unsigned                 gap;
   } plan_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      row_end;
      logic                      frame_end;
   } decimated_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [PIXEL_W-1:0]   req_pixel = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0]   rsp_value;
   logic                        rsp_row_end;
   logic                        rsp_frame_end;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   csr_index_type               csr_index = CSR_VERTICAL_MODE;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   plan_item_type  raster_plan[$];
   decimated_type  decimated_due[$];
   int unsigned    mismatch_count = 0;

   // Bench copy of the filter registers and frame position.
   logic                        cfg_vertical;
   logic [2:0]                  cfg_taps;
   logic [10:0]                 cfg_width;
   logic [10:0]                 cfg_height;
   logic signed [COEF_W-1:0]    cfg_coef [NUM_COEF];
   int unsigned                 at_col;
   int unsigned                 at_row;
   int unsigned                 at_phase;
   longint                      run_sum;
   longint                      col_sum [DEF_MAX_WIDTH];

   int unsigned gap_left = 0;
   int unsigned settle_count = 0;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned quiet_cycles = 0;
   bit          calm_sink = 1'b0;

   always #10 clock = ~clock;

   block_decimating_axis_filter DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int unsigned idle_span(input bit calm);
      int unsigned r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_coef();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'h4000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_pixel(input logic signed [PIXEL_W-1:0] px, input int unsigned gap);
      plan_item_type item;
      item.kind  = PLAN_PIXEL;
      item.pixel = px;
      item.index = CSR_VERTICAL_MODE;
      item.data  = '0;
      item.gap   = gap;
      raster_plan.push_back(item);
   endtask

   task automatic add_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      plan_item_type item;
      item.kind  = PLAN_REGISTER;
      item.pixel = '0;
      item.index = idx;
      item.data  = data;
      item.gap   = 0;
      raster_plan.push_back(item);
   endtask

   // The sender holds off until every expected result has come and the pipe is quiet.
   task automatic add_drain();
      plan_item_type item;
      item.kind  = PLAN_DRAIN;
      item.pixel = '0;
      item.index = CSR_VERTICAL_MODE;
      item.data  = '0;
      item.gap   = 0;
      raster_plan.push_back(item);
   endtask

   task automatic set_geometry(input int unsigned vert, input int unsigned taps,
                               input int unsigned w, input int unsigned h);
      add_drain();
      add_register(CSR_VERTICAL_MODE, 16'(vert));
      add_register(CSR_TAPS, 16'(taps));
      add_register(CSR_IMAGE_WIDTH, 16'(w));
      add_register(CSR_IMAGE_HEIGHT, 16'(h));
   endtask

   task automatic set_coefs(input logic [CSR_DATA_W-1:0] c0, input logic [CSR_DATA_W-1:0] c1,
                            input logic [CSR_DATA_W-1:0] c2, input logic [CSR_DATA_W-1:0] c3);
      add_drain();
      add_register(CSR_COEF_ZERO, c0);
      add_register(CSR_COEF_ONE, c1);
      add_register(CSR_COEF_TWO, c2);
      add_register(CSR_COEF_THREE, c3);
   endtask

   // Random pixels; now and then the sender pauses part way until the results are in.
   task automatic add_pixels(input int unsigned count);
      int unsigned cut;
      bit          calm;
      calm = ($urandom_range(0, 3) == 0);
      cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, count) : count + 1;
      for (int unsigned i = 0; i < count; i++) begin
         if (i == cut) begin
            add_drain();
         end
         add_pixel(random_pixel(), idle_span(calm));
      end
   endtask

   task automatic restart_frame();
      at_col   = 0;
      at_row   = 0;
      at_phase = 0;
      run_sum  = 0;
   endtask

   task automatic apply_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_VERTICAL_MODE: begin
            cfg_vertical = data[0];
            restart_frame();
         end
         CSR_TAPS: begin
            cfg_taps = data[2:0];
            restart_frame();
         end
         CSR_IMAGE_WIDTH: begin
            cfg_width = data[10:0];
            restart_frame();
         end
         CSR_IMAGE_HEIGHT: begin
            cfg_height = data[10:0];
            restart_frame();
         end
         CSR_COEF_ZERO:  cfg_coef[0] = data;
         CSR_COEF_ONE:   cfg_coef[1] = data;
         CSR_COEF_TWO:   cfg_coef[2] = data;
         CSR_COEF_THREE: cfg_coef[3] = data;
         default: ;
      endcase
   endtask

   // Accumulates one pixel and queues the decimated sample when a block completes.
   task automatic filter_pixel(input logic signed [PIXEL_W-1:0] px);
      int unsigned    taps, w, h, x, y, ph, lim;
      longint         prod, sum, quot;
      bit             emit, rend, fend;
      decimated_type  sample;
      taps = (cfg_taps == 0) ? 1 : ((cfg_taps > DEF_MAX_TAPS) ? DEF_MAX_TAPS : cfg_taps);
      w = (cfg_width == 0) ? 1 : ((cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_width);
      h = (cfg_height == 0) ? 1 : ((cfg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_height);
      x = at_col % w;
      y = at_row % h;
      ph = at_phase % taps;
      prod = longint'(px) * longint'(cfg_coef[ph]);
      emit = 1'b0;
      rend = 1'b0;
      fend = 1'b0;
      sum = 0;
      if (!cfg_vertical) begin
         lim = (w / taps) * taps;
         if (x < lim) begin
            sum = ((ph == 0) ? 64'sd0 : run_sum) + prod;
            run_sum = sum;
            if (ph == taps - 1) begin
               emit = 1'b1;
               rend = (x == lim - 1);
               fend = rend && (y == h - 1);
            end
         end
         ph = (ph + 1) % taps;
         if (x + 1 >= w) begin
            x = 0;
            ph = 0;
            y = (y + 1 >= h) ? 0 : y + 1;
         end else begin
            x++;
         end
      end else begin
         lim = (h / taps) * taps;
         if (y < lim) begin
            sum = ((ph == 0) ? 64'sd0 : col_sum[x]) + prod;
            col_sum[x] = sum;
            if (ph == taps - 1) begin
               emit = 1'b1;
               rend = (x == w - 1);
               fend = rend && (y == lim - 1);
            end
         end
         // The tap phase advances once per row in this mode.
         if (x + 1 >= w) begin
            x = 0;
            if (y + 1 >= h) begin
               y = 0;
               ph = 0;
            end else begin
               y++;
               ph = (ph + 1) % taps;
            end
         end else begin
            x++;
         end
      end
      at_col   = x;
      at_row   = y;
      at_phase = ph;
      if (emit) begin
         quot = sum >>> FRAC_BITS;
         if (quot > 262143) begin
            quot = 262143;
         end else if (quot < -262144) begin
            quot = -262144;
         end
         sample.value     = quot[VALUE_W-1:0];
         sample.row_end   = rend;
         sample.frame_end = fend;
         decimated_due.push_back(sample);
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) begin
         $display("%0t ns: %s", $time, what);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin : drive_requests
      plan_item_type item;
      logic          held;
      logic          next_req;
      logic          next_csr;
      if (reset) begin
         req_valid <= 1'b0;
         req_pixel <= '0;
         csr_valid <= 1'b0;
         csr_index <= CSR_VERTICAL_MODE;
         csr_data  <= '0;
         gap_left = 0;
         settle_count = 0;
      end else begin
         held = (req_valid && req_stall) || (csr_valid && !csr_ready);
         if (!held) begin
            next_req = 1'b0;
            next_csr = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (raster_plan.size() > 0) begin
               case (raster_plan[0].kind)
                  PLAN_PIXEL: begin
                     item = raster_plan.pop_front();
                     req_pixel <= item.pixel;
                     next_req = 1'b1;
                     gap_left = item.gap;
                  end
                  PLAN_REGISTER: begin
                     item = raster_plan.pop_front();
                     csr_index <= item.index;
                     csr_data  <= item.data;
                     next_csr = 1'b1;
                  end
                  default: begin
                     if (decimated_due.size() != 0) begin
                        settle_count = 0;
                     end else if (settle_count < SETTLE_CYCLES) begin
                        settle_count++;
                     end else begin
                        settle_count = 0;
                        item = raster_plan.pop_front();
                     end
                  end
               endcase
            end
            req_valid <= next_req;
            csr_valid <= next_csr;
         end
      end
   end

   always @(posedge clock) begin : watch_ports
      decimated_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
         cfg_vertical = 1'b0;
         cfg_taps     = 3'(RST_TAPS);
         cfg_width    = 11'(RST_IMAGE_WIDTH);
         cfg_height   = 11'(RST_IMAGE_HEIGHT);
         cfg_coef[0]  = RST_COEF_ZERO;
         cfg_coef[1]  = RST_COEF_ONE;
         cfg_coef[2]  = RST_COEF_TWO;
         cfg_coef[3]  = RST_COEF_THREE;
         restart_frame();
         foreach (col_sum[i]) begin
            col_sum[i] = 0;
         end
         stall_left = 0;
         cycle_count = 0;
         calm_sink = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
         end
         if (req_valid && !req_stall) begin
            filter_pixel(req_pixel);
         end
         if (rsp_valid && !rsp_stall) begin
            if (decimated_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: value %0d", rsp_value));
            end else begin
               due = decimated_due.pop_front();
               if (rsp_value !== due.value) begin
                  report_mismatch($sformatf("value: expected %0d, got %0d",
                                            due.value, rsp_value));
               end
               if (rsp_row_end !== due.row_end) begin
                  report_mismatch($sformatf("row_end: expected %0b, got %0b",
                                            due.row_end, rsp_row_end));
               end
               if (rsp_frame_end !== due.frame_end) begin
                  report_mismatch($sformatf("frame_end: expected %0b, got %0b",
                                            due.frame_end, rsp_frame_end));
               end
            end
         end
         cycle_count++;
         if (cycle_count % 300 == 0) begin
            calm_sink = ($urandom_range(0, 3) == 0);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_span(calm_sink);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (csr_valid && csr_ready) ||
          (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL block_decimating_axis_filter");
         $finish;
      end
   end

   initial begin : run_test
      logic signed [PIXEL_W-1:0] horizontal_rows [12] = '{
         16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd5, 16'sd6,
         16'sh7FFF, -16'sd1, 16'sd1, 16'sd0, 16'sh8000, 16'sh7FFF
      };
      logic signed [PIXEL_W-1:0] column_rows [6] = '{
         16'sd1, 16'sd2, 16'sh8000, -16'sd1, 16'sh7FFF, 16'sh8000
      };
      int unsigned sent;
      int unsigned wcode;
      int unsigned hcode;
      int unsigned area;

      // Four products of the most negative values saturate; leftover pixels give nothing.
      set_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      set_geometry(0, 4, 6, 2);
      foreach (horizontal_rows[i]) begin
         add_pixel(horizontal_rows[i], idle_span(1'b0));
      end

      // Oversized taps act as four and a zero height as one, so no group completes.
      set_geometry(1, 7, 2, 0);
      add_pixel(16'sd100, 0);
      add_pixel(-16'sd100, 0);

      // Column sums across two rows, with new coefficients between the rows.
      set_geometry(1, 2, 3, 2);
      for (int i = 0; i < 3; i++) begin
         add_pixel(column_rows[i], idle_span(1'b0));
      end
      set_coefs(16'h4000, 16'hC000, 16'h0001, 16'hFFFF);
      for (int i = 3; i < 6; i++) begin
         add_pixel(column_rows[i], idle_span(1'b0));
      end

      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         if ($urandom_range(0, 1) == 0) begin
            set_coefs(random_coef(), random_coef(), random_coef(), random_coef());
         end
         if ($urandom_range(0, 7) == 0) begin
            wcode = $urandom_range(11, 48);
            hcode = $urandom_range(0, 3);
         end else begin
            wcode = $urandom_range(0, 9);
            hcode = $urandom_range(0, 8);
         end
         set_geometry($urandom_range(0, 1), $urandom_range(0, 7), wcode, hcode);
         area = ((wcode == 0) ? 1 : wcode) * ((hcode == 0) ? 1 : hcode);
         area = area * $urandom_range(1, 2) + $urandom_range(0, area - 1);
         add_pixels(area);
         sent += area;
      end

      // Full-width geometry: a width past the maximum acts as the maximum, every
      // column of the line memory is written, and the frame wraps after one row.
      set_coefs(random_coef(), random_coef(), random_coef(), random_coef());
      set_geometry(1, 1, 2047, 1);
      add_pixels(DEF_MAX_WIDTH + 3);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (raster_plan.size() != 0 || req_valid || csr_valid) begin
         @(negedge clock);
      end
      while (decimated_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS block_decimating_axis_filter");
      end else begin
         $display("FAIL block_decimating_axis_filter");
      end
      $finish;
   end

endmodule
